// ----- hw/rtl/sha256_stream_hasher_macros.svh -----
// Assertion macros shared by the SHA-256 stream hasher RTL.
`ifndef SHA256_STREAM_HASHER_MACROS_SVH
`define SHA256_STREAM_HASHER_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising edge outside reset.
`define SHS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("SHA-256 hasher check failed");
// Next-cycle implication, checked on every rising edge outside reset.
`define SHS_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("SHA-256 hasher check failed");
`else
`define SHS_ASSERT_IMP(label, ante, cons)
`define SHS_ASSERT_NXT(label, ante, cons)
`endif
`endif

// ----- hw/rtl/shs_pkg.sv -----
// Types and constants shared by the SHA-256 stream hasher modules.
package shs_pkg;

    localparam int WORD_W  = 32;
    localparam int HASH_N  = 8;
    localparam int ROUND_N = 64;
    localparam int ROUND_W = 6;
    localparam int FILL_W  = 6;
    localparam int BLOCK_W = 512;

    typedef logic [WORD_W-1:0] word_t;
    typedef word_t hash_t [HASH_N];

    // Schedule window taps needed by one round.
    typedef struct packed {
        word_t w0;
        word_t w1;
        word_t w9;
        word_t w14;
    } shs_sched_t;

    localparam logic [FILL_W-1:0] FILL_LAST = 6'd63;
    localparam logic [FILL_W-1:0] LEN_POS   = 6'd56;
    localparam logic [ROUND_W-1:0] ROUND_LAST = 6'd63;
    localparam logic [2:0] LAST_WORD = 3'd7;
    localparam logic [7:0] PAD_MARK  = 8'h80;

    localparam hash_t INIT_HASH = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam word_t ROUND_K [ROUND_N] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

endpackage

// ----- hw/rtl/shs_in_if.sv -----
// Byte stream channel of the SHA-256 stream hasher.
interface shs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_message;

    modport source (output valid, output data_byte, output has_byte,
                    output end_of_message, input ready);
    modport sink   (input valid, input data_byte, input has_byte,
                    input end_of_message, output ready);
endinterface

// ----- hw/rtl/shs_out_if.sv -----
// Digest word channel of the SHA-256 stream hasher.
interface shs_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_number;
    logic        final_word;

    modport source (output valid, output digest_word, output word_number,
                    output final_word, input ready);
    modport sink   (input valid, input digest_word, input word_number,
                    input final_word, output ready);
endinterface

// ----- hw/rtl/shs_round.sv -----
// One SHA-256 compression round with its message schedule step.
module shs_round
    import shs_pkg::*;
(
    input  hash_t              work,
    input  shs_sched_t         sched,
    input  logic [ROUND_W-1:0] round_idx,
    output hash_t              work_next,
    output word_t              w_new
);

    function automatic word_t big_sigma0(input word_t x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic word_t big_sigma1(input word_t x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic word_t small_sigma0(input word_t x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic word_t small_sigma1(input word_t x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

    word_t t1;
    word_t t2;
    word_t ch;
    word_t maj;

    // Round function on the working variables a to h.
    always_comb
    begin
        ch  = (work[4] & work[5]) ^ (~work[4] & work[6]);
        maj = (work[0] & work[1]) ^ (work[0] & work[2]) ^ (work[1] & work[2]);
        t1  = work[7] + big_sigma1(work[4]) + ch + ROUND_K[round_idx] + sched.w0;
        t2  = big_sigma0(work[0]) + maj;
        work_next[0] = t1 + t2;
        work_next[1] = work[0];
        work_next[2] = work[1];
        work_next[3] = work[2];
        work_next[4] = work[3] + t1;
        work_next[5] = work[4];
        work_next[6] = work[5];
        work_next[7] = work[6];
    end

    // Schedule word sixteen places ahead of the current one.
    assign w_new = sched.w0 + small_sigma0(sched.w1) + sched.w9 + small_sigma1(sched.w14);

endmodule

// ----- hw/rtl/sha256_stream_hasher.sv -----
// Top level of the SHA-256 stream hasher: byte collection, padding and round sequencer.
//
//   channel      direction  payload                                   handshake
//   byte_stream  sink       data_byte, has_byte, end_of_message       valid/ready
//   digest       source     digest_word, word_number, final_word      valid/ready
//
// A transaction that fills the 64-byte block starts a compression (64 rounds
// through the shared round unit, then the add into the chaining words),
// during which ready is low.
// At end of message, padding shifts in one byte a cycle up to the block end,
// followed by one or two compressions, then eight digest transactions.
// Reset clears all control state asynchronously; there is no clearing pass.
// A stalled digest channel holds the block; no byte is taken until all eight
// words are delivered.
module sha256_stream_hasher
    import shs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    shs_in_if.sink    byte_stream,
    shs_out_if.source digest
);

`include "sha256_stream_hasher_macros.svh"

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PAD   = 3'd1;
    localparam logic [2:0] ST_ROUND = 3'd2;
    localparam logic [2:0] ST_FOLD  = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    logic [2:0]         state_reg, state_next;
    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic [63:0]        msg_bytes_reg, msg_bytes_next;
    logic               end_pend_reg, end_pend_next;
    logic               mark_done_reg, mark_done_next;
    logic               pad_extra_reg, pad_extra_next;
    logic [ROUND_W-1:0] round_reg, round_next;
    logic [2:0]         word_reg, word_next;
    hash_t              chain_reg, chain_next;
    hash_t              work_reg;
    logic [BLOCK_W-1:0] blk_reg;

    logic        shift_en;
    logic [7:0]  shift_byte;
    logic        load_work;
    logic        round_en;
    logic [63:0] len_bits;
    logic [2:0]  len_sel;
    logic        in_take;
    logic        out_take;
    logic        blk_full;
    logic        round_done;
    logic        msg_done;
    shs_sched_t  sched;
    hash_t       work_next;
    word_t       w_new;

    assign byte_stream.ready = (state_reg == ST_IDLE);

    // Output payload comes straight from the chaining registers.
    assign digest.valid       = (state_reg == ST_OUT);
    assign digest.digest_word = chain_reg[word_reg];
    assign digest.word_number = word_reg;
    assign digest.final_word  = (word_reg == LAST_WORD);

    // Handshake and sequencing conditions.
    assign in_take    = byte_stream.valid && byte_stream.ready;
    assign out_take   = digest.valid && digest.ready;
    assign blk_full   = byte_stream.has_byte && (fill_reg == FILL_LAST);
    assign round_done = (state_reg == ST_ROUND) && (round_reg == ROUND_LAST);
    assign msg_done   = out_take && digest.final_word;

    // Length field bytes, most significant first at block positions 56 to 63.
    assign len_bits = {msg_bytes_reg[60:0], 3'b000};
    assign len_sel  = LAST_WORD - fill_reg[2:0];

    // Schedule taps: word 0 of the window sits in the top bits.
    assign sched.w0  = blk_reg[511:480];
    assign sched.w1  = blk_reg[479:448];
    assign sched.w9  = blk_reg[223:192];
    assign sched.w14 = blk_reg[63:32];

    shs_round u_round (
        .work      (work_reg),
        .sched     (sched),
        .round_idx (round_reg),
        .work_next (work_next),
        .w_new     (w_new)
    );

    // Sequencer next-state logic.
    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        msg_bytes_next = msg_bytes_reg;
        end_pend_next  = end_pend_reg;
        mark_done_next = mark_done_reg;
        pad_extra_next = pad_extra_reg;
        round_next     = round_reg;
        word_next      = word_reg;
        chain_next     = chain_reg;
        shift_en       = 1'b0;
        shift_byte     = 8'h00;
        load_work      = 1'b0;
        round_en       = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    end_pend_next = byte_stream.end_of_message;
                    if (byte_stream.has_byte)
                    begin
                        shift_en       = 1'b1;
                        shift_byte     = byte_stream.data_byte;
                        fill_next      = fill_reg + 1'b1;
                        msg_bytes_next = msg_bytes_reg + 64'd1;
                    end
                    if (blk_full)
                    begin
                        load_work  = 1'b1;
                        state_next = ST_ROUND;
                    end
                    else if (byte_stream.end_of_message)
                    begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD:
            begin
                shift_en  = 1'b1;
                fill_next = fill_reg + 1'b1;
                if (!mark_done_reg)
                begin
                    shift_byte     = PAD_MARK;
                    mark_done_next = 1'b1;
                    pad_extra_next = (fill_reg >= LEN_POS);
                end
                else if ((fill_reg >= LEN_POS) && !pad_extra_reg)
                begin
                    shift_byte = len_bits[{len_sel, 3'b000} +: 8];
                end
                if (fill_reg == FILL_LAST)
                begin
                    load_work  = 1'b1;
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                round_en   = 1'b1;
                round_next = round_reg + 1'b1;
                if (round_done)
                begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD:
            begin
                for (int i = 0; i < HASH_N; i++)
                begin
                    chain_next[i] = chain_reg[i] + work_reg[i];
                end
                if (!end_pend_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (mark_done_reg && !pad_extra_reg)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    pad_extra_next = 1'b0;
                    state_next     = ST_PAD;
                end
            end
            ST_OUT:
            begin
                if (out_take)
                begin
                    word_next = word_reg + 1'b1;
                    if (msg_done)
                    begin
                        chain_next     = INIT_HASH;
                        msg_bytes_next = 64'd0;
                        end_pend_next  = 1'b0;
                        mark_done_next = 1'b0;
                        pad_extra_next = 1'b0;
                        state_next     = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and chaining state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            msg_bytes_reg <= '0;
            end_pend_reg  <= 1'b0;
            mark_done_reg <= 1'b0;
            pad_extra_reg <= 1'b0;
            round_reg     <= '0;
            word_reg      <= '0;
            chain_reg     <= INIT_HASH;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            msg_bytes_reg <= msg_bytes_next;
            end_pend_reg  <= end_pend_next;
            mark_done_reg <= mark_done_next;
            pad_extra_reg <= pad_extra_next;
            round_reg     <= round_next;
            word_reg      <= word_next;
            chain_reg     <= chain_next;
        end
    end

    // Block buffer doubles as the schedule window; working variables follow it.
    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            blk_reg <= {blk_reg[BLOCK_W-9:0], shift_byte};
        end
        else if (round_en)
        begin
            blk_reg <= {blk_reg[BLOCK_W-WORD_W-1:0], w_new};
        end

        if (load_work)
        begin
            work_reg <= chain_reg;
        end
        else if (round_en)
        begin
            work_reg <= work_next;
        end
    end

    // Digest words only appear on a block boundary.
    `SHS_ASSERT_IMP(a_out_on_boundary, digest.valid, fill_reg == '0)
    // The sixty-fourth round always hands over to the chaining add.
    `SHS_ASSERT_NXT(a_round_to_fold, round_done, state_reg == ST_FOLD)
    // A byte completing the block starts a compression from round zero.
    `SHS_ASSERT_NXT(a_full_starts, in_take && blk_full, (state_reg == ST_ROUND) && (round_reg == '0))
    // After the last digest word the next message starts from the initial values.
    `SHS_ASSERT_NXT(a_restart, msg_done, (chain_reg[0] == INIT_HASH[0]) && (msg_bytes_reg == '0))

endmodule
